// ----- design/v3rn_pkg.sv -----
// Shared types and constants for the 3D vector resize pipeline.
package v3rn_pkg;

   localparam int unsigned CompW   = 32;
   localparam int unsigned RootW   = 32;
   localparam int unsigned RemW    = RootW + 2;
   localparam int unsigned ProdW   = 2 * CompW;
   localparam int unsigned NumLane = 3;

   localparam logic [CompW-1:0] PosLimit = 32'h7FFF_FFFF;
   localparam logic [CompW-1:0] NegLimit = 32'h8000_0000;

   // Payload that rides along the square root chain untouched.
   typedef struct packed {
      logic [NumLane-1:0][ProdW-1:0] prod;
      logic [NumLane-1:0]            neg;
   } carry_type;

   // One square root cell's state.
   typedef struct packed {
      logic [ProdW-1:0] sum;
      logic [RemW-1:0]  rem;
      logic [RootW-1:0] root;
      carry_type        carry;
   } sqrt_stage_type;

   // One lane of the quotient chain.
   typedef struct packed {
      logic [CompW-1:0] rem;
      logic [CompW-1:0] quo;
      logic             big;
      logic             neg;
   } div_lane_type;

   // One division cell's state.
   typedef struct packed {
      logic [NumLane-1:0] [$bits(div_lane_type)-1:0] lane;
      logic [RootW-1:0]   len;
   } div_stage_type;

endpackage

// ----- design/v3rn_sqrt_cell.sv -----
// One cell of the digit-by-digit square root chain: one root bit per cell.
module v3rn_sqrt_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  v3rn_pkg::sqrt_stage_type in_data,
   output logic                    out_valid,
   output v3rn_pkg::sqrt_stage_type out_data
);
   import v3rn_pkg::*;

   logic           valid_ff;
   sqrt_stage_type data_ff, data_in;
   logic [RemW-1:0] r2, trial;
   logic            ge;

   // Bring in the next two radicand bits and try the next root bit.
   always_comb begin
      r2    = {in_data.rem[RemW-3:0], in_data.sum[ProdW-1 -: 2]};
      trial = {in_data.root, 2'b01};
      ge    = (r2 >= trial);
      data_in       = in_data;
      data_in.sum   = {in_data.sum[ProdW-3:0], 2'b00};
      data_in.rem   = ge ? (r2 - trial) : r2;
      data_in.root  = {in_data.root[RootW-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
endmodule

// ----- design/v3rn_div_cell.sv -----
// One cell of the restoring division chain: one quotient bit per lane per cell.
module v3rn_div_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_valid,
   input  v3rn_pkg::div_stage_type in_data,
   output logic                   out_valid,
   output v3rn_pkg::div_stage_type out_data
);
   import v3rn_pkg::*;

   logic          valid_ff;
   div_stage_type data_ff, data_in;
   div_lane_type  li, lo;
   logic [CompW:0] r2;
   logic           ge;

   // Shift one dividend bit into each partial remainder and subtract if it fits.
   always_comb begin
      data_in = in_data;
      li = '0;
      lo = '0;
      r2 = '0;
      ge = 1'b0;
      for (int i = 0; i < NumLane; i++) begin
         li = div_lane_type'(in_data.lane[i]);
         r2 = {li.rem, li.quo[CompW-1]};
         ge = (r2 >= {1'b0, in_data.len});
         lo = li;
         lo.rem = ge ? CompW'(r2 - {1'b0, in_data.len}) : r2[CompW-1:0];
         lo.quo = {li.quo[CompW-2:0], ge};
         data_in.lane[i] = lo;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
endmodule

// ----- design/vector3_resize_normalize.sv -----
// Top level of the 3D vector resize block: multiply, square root and divide chains.
//
// Input channel (req_): one transaction carries vec_x, vec_y, vec_z (signed
// Q16.16) and target_length (unsigned Q16.16). Result channel (rsp_): one
// transaction per input with out_x, out_y, out_z, orig_length and the
// zero_error and saturated flags in rsp_tuser.
// Stages from input to output register: the multipliers, the sum of the
// squares, 32 square root cells of one bit each, the quotient setup, 32
// division cells and the output register. One vector is accepted every
// cycle while the receiver is not stalling; the pipeline is a chain of
// cells that all advance together.
// When the receiver stalls with a result waiting, the whole chain holds
// and req_tready drops until the result is taken.
// Reset clears all valid flags; no result is pending afterward.
// A zero vector returns zeros with zero_error set. Scaled components that
// leave the signed 32-bit range are clamped and set saturated.
module vector3_resize_normalize (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // {target_length, vec_z, vec_y, vec_x} from the lowest bit up: x, y, z, target
   input  logic [127:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // From the lowest bit up: out_x, out_y, out_z, orig_length
   output logic [127:0] rsp_tdata,
   // From the lowest bit up: zero_error, saturated
   output logic [1:0]   rsp_tuser
);
   import v3rn_pkg::*;

   logic adv;
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   // Stage one: magnitudes, squares and products.
   logic                          m_valid_ff;
   logic [NumLane-1:0][ProdW-1:0] sq_ff;
   carry_type                     m_carry_ff;
   logic [NumLane-1:0][CompW-1:0] mag;
   logic [CompW-1:0]              comp, tgt;

   always_comb begin
      tgt = req_tdata[4*CompW-1 -: CompW];
      for (int i = 0; i < NumLane; i++) begin
         comp   = req_tdata[i*CompW +: CompW];
         mag[i] = comp[CompW-1] ? (-comp) : comp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else if (adv) begin
         m_valid_ff <= req_tvalid;
      end
      if (adv) begin
         for (int i = 0; i < NumLane; i++) begin
            sq_ff[i]            <= ProdW'(mag[i]) * ProdW'(mag[i]);
            m_carry_ff.prod[i]  <= ProdW'(mag[i]) * ProdW'(tgt);
            m_carry_ff.neg[i]   <= req_tdata[i*CompW + CompW-1];
         end
      end
   end

   // Stage two: sum of squares, seed of the root chain.
   logic           s_valid_ff;
   sqrt_stage_type s_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s_valid_ff <= 1'b0;
      end else if (adv) begin
         s_valid_ff <= m_valid_ff;
      end
      if (adv) begin
         s_data_ff.sum   <= sq_ff[0] + sq_ff[1] + sq_ff[2];
         s_data_ff.rem   <= '0;
         s_data_ff.root  <= '0;
         s_data_ff.carry <= m_carry_ff;
      end
   end

   // Square root chain.
   logic           sq_valid [RootW+1];
   sqrt_stage_type sq_data  [RootW+1];
   assign sq_valid[0] = s_valid_ff;
   assign sq_data[0]  = s_data_ff;

   for (genvar k = 0; k < RootW; k++) begin : g_sqrt
      v3rn_sqrt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (adv),
         .in_valid (sq_valid[k]),
         .in_data  (sq_data[k]),
         .out_valid(sq_valid[k+1]),
         .out_data (sq_data[k+1])
      );
   end

   // Division setup: overflow check on the high product half.
   logic          d_valid_ff;
   div_stage_type d_data_ff, d_data_in;
   div_lane_type  dl;
   sqrt_stage_type rs;

   always_comb begin
      rs = sq_data[RootW];
      d_data_in.len = rs.root;
      dl = '0;
      for (int i = 0; i < NumLane; i++) begin
         dl.big = (rs.carry.prod[i][ProdW-1 -: CompW] >= rs.root);
         dl.rem = dl.big ? '0 : rs.carry.prod[i][ProdW-1 -: CompW];
         dl.quo = rs.carry.prod[i][CompW-1:0];
         dl.neg = rs.carry.neg[i];
         d_data_in.lane[i] = dl;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else if (adv) begin
         d_valid_ff <= sq_valid[RootW];
      end
      if (adv) begin
         d_data_ff <= d_data_in;
      end
   end

   // Division chain.
   logic          dv_valid [CompW+1];
   div_stage_type dv_data  [CompW+1];
   assign dv_valid[0] = d_valid_ff;
   assign dv_data[0]  = d_data_ff;

   for (genvar k = 0; k < CompW; k++) begin : g_div
      v3rn_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (adv),
         .in_valid (dv_valid[k]),
         .in_data  (dv_data[k]),
         .out_valid(dv_valid[k+1]),
         .out_data (dv_data[k+1])
      );
   end

   // Output stage: sign, clamp and zero-length handling.
   logic                          o_valid_ff;
   logic [127:0]                  o_data_ff, o_data_in;
   logic [1:0]                    o_user_ff, o_user_in;
   div_stage_type                 fd;
   div_lane_type                  fl;
   logic                          zero, sat, lsat;
   logic [NumLane-1:0][CompW-1:0] res;

   always_comb begin
      fd   = dv_data[CompW];
      zero = (fd.len == '0);
      sat  = 1'b0;
      fl   = '0;
      lsat = 1'b0;
      for (int i = 0; i < NumLane; i++) begin
         fl = div_lane_type'(fd.lane[i]);
         if (fl.neg) begin
            lsat   = fl.big || (fl.quo > NegLimit);
            res[i] = lsat ? NegLimit : (-fl.quo);
         end else begin
            lsat   = fl.big || fl.quo[CompW-1];
            res[i] = lsat ? PosLimit : fl.quo;
         end
         sat = sat | lsat;
      end
      if (zero) begin
         o_data_in = '0;
         o_user_in = 2'b01;
      end else begin
         o_data_in = {fd.len, res[2], res[1], res[0]};
         o_user_in = {sat, 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
      end else if (adv) begin
         o_valid_ff <= dv_valid[CompW];
      end
      if (adv) begin
         o_data_ff <= o_data_in;
         o_user_ff <= o_user_in;
      end
   end

   assign rsp_tvalid = o_valid_ff;
   assign rsp_tdata  = o_data_ff;
   assign rsp_tuser  = o_user_ff;

   // A zero-length result carries all-zero data.
   a_zero_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("zero_error with nonzero data");

   // A zero-length result is never flagged saturated.
   a_zero_nosat: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> !rsp_tuser[1])
      else $error("zero_error and saturated together");

   // The chain holds while the output waits.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(d_data_ff) && $stable(s_data_ff))
      else $error("pipeline moved during stall");
endmodule
